FILE: rtl/cdad_pkg.sv
// Shared types, constants and calendar helper functions for the date offset block.
package cdad_pkg;

  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int RES_W   = 9;   // holds a year residue modulo 400

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [RES_W-1:0] LEAP_CYCLE_LAST = 9'd399;
  localparam logic [RES_W:0]   LEAP_CYCLE      = 10'd400;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SUB = 1'b1;

  typedef struct packed {
    logic start;   // load a new walk
    logic run;     // walk the months; otherwise echo the loaded date
    logic sub;     // walk backward
  } walk_cmd_t;

  typedef struct packed {
    logic done;
    logic wrapped;
  } walk_stat_t;

  // Leap rule evaluated on the year residue modulo 400.
  function automatic logic leap_f(input logic [RES_W-1:0] r);
    logic century;
    century = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
    return ((r[1:0] == 2'd0) && !century) || (r == 9'd0);
  endfunction

  function automatic logic [DAY_W-1:0] month_len_f(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [DAY_W-1:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      MONTH_FEB:                                  n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: rtl/calendar_date_add_sub_days.sv
// Path from input transfer to out_valid: the mod400 unit builds the year residue modulo 400,
// then S_RES checks the date and loads the month walk, which is skipped (date echoed) for an
// invalid date or a zero count; the result then waits in S_FIN for the output register.
// One item at a time; in_ready is high only when idle, so a new item can start in the cycle after
// the result loads, later while out_ready holds back the finished result.
// Reset (synchronous, rst_n low) returns to idle and drops out_valid.
module calendar_date_add_sub_days #(
  parameter int COUNT_BITS = 16,
  parameter int YEAR_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [YEAR_BITS-1:0]          in_start_year,
  input  logic [cdad_pkg::MONTH_W-1:0]  in_start_month,
  input  logic [cdad_pkg::DAY_W-1:0]    in_start_day,
  input  logic [COUNT_BITS-1:0]         in_day_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [YEAR_BITS-1:0]          out_result_year,
  output logic [cdad_pkg::MONTH_W-1:0]  out_result_month,
  output logic [cdad_pkg::DAY_W-1:0]    out_result_day,
  output logic                          out_input_valid,
  output logic                          out_year_wrapped
);
  import cdad_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RES  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic                  op_r;
  logic [YEAR_BITS-1:0]  year_r;
  logic [MONTH_W-1:0]    month_r;
  logic [DAY_W-1:0]      day_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic                  ok_r, ok_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [YEAR_BITS-1:0]  out_year_r;
  logic [MONTH_W-1:0]    out_month_r;
  logic [DAY_W-1:0]      out_day_r;
  logic                  out_ok_r;
  logic                  out_wrap_r;

  logic                  in_fire, out_load;
  logic                  mod_done;
  logic [RES_W-1:0]      mod_rem;
  logic                  date_ok;
  logic [DAY_W-1:0]      start_len;
  walk_cmd_t             cmd;
  walk_stat_t            stat;
  logic [YEAR_BITS-1:0]  w_year;
  logic [MONTH_W-1:0]    w_month;
  logic [DAY_W-1:0]      w_day;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  cdad_mod400 #(.YEAR_BITS(YEAR_BITS)) u_mod400 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire),
    .value (in_start_year),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  always_comb begin
    start_len = month_len_f(month_r, leap_f(mod_rem));
    date_ok   = (month_r >= MONTH_JAN) && (month_r <= MONTH_DEC) &&
                (day_r != '0) && (day_r <= start_len);
    cmd.start = (state_r == S_RES) && mod_done;
    cmd.run   = date_ok && (cnt_r != '0);
    cmd.sub   = (op_r == OP_SUB);
  end

  cdad_walk #(.COUNT_BITS(COUNT_BITS), .YEAR_BITS(YEAR_BITS)) u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .ld_year  (year_r),
    .ld_month (month_r),
    .ld_day   (day_r),
    .ld_count (cnt_r),
    .ld_res   (mod_rem),
    .stat     (stat),
    .year     (w_year),
    .month    (w_month),
    .day      (w_day)
  );

  // Hold the finished result until the output register frees up.
  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    ok_nxt    = ok_r;
    case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_RES;
      S_RES: begin
        if (mod_done) begin
          ok_nxt    = date_ok;
          state_nxt = S_WALK;
        end
      end
      S_WALK: if (stat.done) state_nxt = S_FIN;
      S_FIN:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ok_r <= ok_nxt;
    if (in_fire) begin
      op_r    <= in_opcode;
      year_r  <= in_start_year;
      month_r <= in_start_month;
      day_r   <= in_start_day;
      cnt_r   <= in_day_count;
    end
    if (out_load) begin
      out_year_r  <= w_year;
      out_month_r <= w_month;
      out_day_r   <= w_day;
      out_ok_r    <= ok_r;
      out_wrap_r  <= stat.wrapped;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_year  = out_year_r;
  assign out_result_month = out_month_r;
  assign out_result_day   = out_day_r;
  assign out_input_valid  = out_ok_r;
  assign out_year_wrapped = out_wrap_r;

endmodule

FILE: rtl/cdad_mod400.sv
// Year residue modulo 400 by reciprocal multiplication; the quotient and then the remainder are registered.
module cdad_mod400 #(
  parameter int YEAR_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [YEAR_BITS-1:0]        value,
  output logic                        done,
  output logic [cdad_pkg::RES_W-1:0]  rem
);
  import cdad_pkg::*;

  // 400 = 16 * 25: drop the low four bits, then divide what is left by 25
  localparam int LOW_BITS = 4;
  localparam int TW       = YEAR_BITS - LOW_BITS;
  localparam int SH       = TW + 5;
  localparam int PW       = 2 * TW + 1;
  localparam int QW       = TW - 4;
  localparam longint unsigned RECIP = ((64'd1 << SH) + 64'd24) / 64'd25;

  logic                 s1_r, s1_nxt;
  logic                 s2_r, s2_nxt;
  logic                 done_r, done_nxt;
  logic [YEAR_BITS-1:0] val_r, val_nxt;
  logic [QW-1:0]        q_r, q_nxt;
  logic [RES_W-1:0]     rem_r, rem_nxt;
  logic [PW-1:0]        prod;

  always_comb begin
    prod     = PW'(val_r[YEAR_BITS-1:LOW_BITS]) * PW'(RECIP);
    s1_nxt   = start;
    s2_nxt   = s1_r;
    done_nxt = s2_r;
    val_nxt  = start ? value : val_r;
    q_nxt    = prod[PW-1:SH];
    // the true remainder is below 400, so the low bits of the difference suffice
    rem_nxt  = RES_W'(val_r) - RES_W'(q_r) * RES_W'(LEAP_CYCLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= 1'b0;
      s2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= s1_nxt;
      s2_r   <= s2_nxt;
      done_r <= done_nxt;
    end
    val_r <= val_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

FILE: rtl/cdad_walk.sv
// Month walk: one shared subtract-compare unit steps the date one month per cycle.
module cdad_walk #(
  parameter int COUNT_BITS = 16,
  parameter int YEAR_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cdad_pkg::walk_cmd_t           cmd,
  input  logic [YEAR_BITS-1:0]          ld_year,
  input  logic [cdad_pkg::MONTH_W-1:0]  ld_month,
  input  logic [cdad_pkg::DAY_W-1:0]    ld_day,
  input  logic [COUNT_BITS-1:0]         ld_count,
  input  logic [cdad_pkg::RES_W-1:0]    ld_res,
  output cdad_pkg::walk_stat_t          stat,
  output logic [YEAR_BITS-1:0]          year,
  output logic [cdad_pkg::MONTH_W-1:0]  month,
  output logic [cdad_pkg::DAY_W-1:0]    day
);
  import cdad_pkg::*;

  localparam int AW = COUNT_BITS + 1;
  localparam longint unsigned YMAX = (64'd1 << YEAR_BITS) - 64'd1;
  localparam logic [RES_W-1:0] YMAX_RES = RES_W'(YMAX % 400);
  localparam logic [YEAR_BITS-1:0] YEAR_TOP = {YEAR_BITS{1'b1}};

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic                 sub_r, sub_nxt;
  logic                 wrap_r, wrap_nxt;
  logic [AW-1:0]        acc_r, acc_nxt;
  logic [DAY_W-1:0]     day_r, day_nxt;
  logic [MONTH_W-1:0]   month_r, month_nxt;
  logic [YEAR_BITS-1:0] year_r, year_nxt;
  logic [RES_W-1:0]     res_r, res_nxt;

  logic [DAY_W-1:0]     md_cur, operand, md_step;
  logic [AW:0]          diff;
  logic                 borrow, step;
  logic                 roll;
  logic [MONTH_W-1:0]   m_step;
  logic [YEAR_BITS-1:0] y_step;
  logic [RES_W-1:0]     r_step;
  logic                 w_step;

  always_comb begin
    md_cur  = month_len_f(month_r, leap_f(res_r));
    operand = sub_r ? day_r : md_cur;
    diff    = {1'b0, acc_r} - {{(AW+1-DAY_W){1'b0}}, operand};
    borrow  = diff[AW];
    // forward: keep going while the day is past the month end
    step    = sub_r ? !borrow : (!borrow && (diff[AW-1:0] != '0));

    y_step = year_r;
    r_step = res_r;
    w_step = wrap_r;
    if (!sub_r) begin
      roll   = (month_r == MONTH_DEC);
      m_step = roll ? MONTH_JAN : month_r + MONTH_W'(1);
      if (roll) begin
        if (year_r == YEAR_TOP) begin
          y_step = '0;
          r_step = '0;
          w_step = 1'b1;
        end else begin
          y_step = year_r + YEAR_BITS'(1);
          r_step = (res_r == LEAP_CYCLE_LAST) ? '0 : res_r + RES_W'(1);
        end
      end
    end else begin
      roll   = (month_r == MONTH_JAN);
      m_step = roll ? MONTH_DEC : month_r - MONTH_W'(1);
      if (roll) begin
        if (year_r == '0) begin
          y_step = YEAR_TOP;
          r_step = YMAX_RES;
          w_step = 1'b1;
        end else begin
          y_step = year_r - YEAR_BITS'(1);
          r_step = (res_r == '0) ? LEAP_CYCLE_LAST : res_r - RES_W'(1);
        end
      end
    end
    md_step = month_len_f(m_step, leap_f(r_step));

    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    sub_nxt   = sub_r;
    wrap_nxt  = wrap_r;
    acc_nxt   = acc_r;
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    res_nxt   = res_r;

    if (cmd.start) begin
      busy_nxt  = cmd.run;
      done_nxt  = !cmd.run;
      sub_nxt   = cmd.sub;
      wrap_nxt  = 1'b0;
      acc_nxt   = cmd.sub ? AW'(ld_count) : AW'(ld_count) + AW'(ld_day);
      day_nxt   = ld_day;
      month_nxt = ld_month;
      year_nxt  = ld_year;
      res_nxt   = ld_res;
    end else if (busy_r) begin
      if (step) begin
        acc_nxt   = diff[AW-1:0];
        month_nxt = m_step;
        year_nxt  = y_step;
        res_nxt   = r_step;
        wrap_nxt  = w_step;
        if (sub_r) begin
          day_nxt = md_step;
        end
      end else begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        day_nxt  = sub_r ? day_r - acc_r[DAY_W-1:0] : acc_r[DAY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    sub_r   <= sub_nxt;
    wrap_r  <= wrap_nxt;
    acc_r   <= acc_nxt;
    day_r   <= day_nxt;
    month_r <= month_nxt;
    year_r  <= year_nxt;
    res_r   <= res_nxt;
  end

  assign stat.done    = done_r;
  assign stat.wrapped = wrap_r;
  assign year         = year_r;
  assign month        = month_r;
  assign day          = day_r;

endmodule

FILE: rtl/cdad_checker.sv
// Port-level checks for the date offset block, bound to the top level.
module cdad_checker #(
  parameter int COUNT_BITS = 16,
  parameter int YEAR_BITS  = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [YEAR_BITS-1:0]          out_result_year,
  input logic [cdad_pkg::MONTH_W-1:0]  out_result_month,
  input logic [cdad_pkg::DAY_W-1:0]    out_result_day,
  input logic                          out_input_valid,
  input logic                          out_year_wrapped
);
  import cdad_pkg::*;

  // A stalled result transfer holds its date and input-valid flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_year) &&
    $stable(out_result_month) && $stable(out_result_day) && $stable(out_input_valid))
    else $error("result changed while stalled");

  // in_ready drops once an item is taken.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input accepted while busy");

  a_invalid_nowrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_input_valid |-> !out_year_wrapped)
    else $error("wrap flagged on an invalid date");

  a_valid_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_input_valid |->
      (out_result_month >= MONTH_JAN) && (out_result_month <= MONTH_DEC) &&
      (out_result_day != '0))
    else $error("result date out of range");

endmodule

bind calendar_date_add_sub_days cdad_checker #(
  .COUNT_BITS (COUNT_BITS),
  .YEAR_BITS  (YEAR_BITS)
) u_cdad_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_year  (out_result_year),
  .out_result_month (out_result_month),
  .out_result_day   (out_result_day),
  .out_input_valid  (out_input_valid),
  .out_year_wrapped (out_year_wrapped)
);

FILE: test/tb.sv
// Self-checking testbench for the calendar date offset block: directed and random date shifts.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cdad_pkg::*;

  localparam int YEAR_W    = 16;
  localparam int COUNT_W   = 16;
  localparam int YEAR_MAX  = (1 << YEAR_W) - 1;
  localparam int COUNT_MAX = (1 << COUNT_W) - 1;
  localparam int N_RANDOM  = 250;
  localparam int DRAIN_CYC = 64;

  typedef struct packed {
    logic               op;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [COUNT_W-1:0] count;
  } date_req_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               valid;
    logic               wrapped;
  } date_res_t;

  class date_shift_board;
    date_res_t expected_dates[$];
    int        mismatches;
    int        n_checked;
    int        n_invalid;
    int        n_wrapped;

    function new();
      mismatches = 0;
      n_checked  = 0;
      n_invalid  = 0;
      n_wrapped  = 0;
    endfunction

    static function bit leap_year(int unsigned y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    static function int unsigned month_length(int unsigned y, int unsigned m);
      int unsigned n;
      case (m)
        1, 3, 5, 7, 8, 10, 12: n = 31;
        4, 6, 9, 11:           n = 30;
        2:                     n = leap_year(y) ? 29 : 28;
        default:               n = 0;
      endcase
      return n;
    endfunction

    // Walk month by month, wrapping the year at both ends of its range.
    function date_res_t shift_date(date_req_t r);
      date_res_t   o;
      int unsigned y, m, d, cnt, md;
      y = r.year;
      m = r.month;
      d = r.day;
      cnt = r.count;
      o.wrapped = 1'b0;
      o.valid = (m >= 1 && m <= 12 && d >= 1 && d <= month_length(y, m));
      if (o.valid && cnt != 0) begin
        if (r.op == OP_ADD) begin
          d = d + cnt;
          md = month_length(y, m);
          while (d > md) begin
            d = d - md;
            m = m + 1;
            if (m > 12) begin
              m = 1;
              if (y == YEAR_MAX) begin
                y = 0;
                o.wrapped = 1'b1;
              end else begin
                y = y + 1;
              end
            end
            md = month_length(y, m);
          end
        end else begin
          while (cnt >= d) begin
            cnt = cnt - d;
            m = m - 1;
            if (m == 0) begin
              m = 12;
              if (y == 0) begin
                y = YEAR_MAX;
                o.wrapped = 1'b1;
              end else begin
                y = y - 1;
              end
            end
            d = month_length(y, m);
          end
          d = d - cnt;
        end
      end
      o.year  = YEAR_W'(y);
      o.month = MONTH_W'(m);
      o.day   = DAY_W'(d);
      return o;
    endfunction

    function void note_input(date_req_t r);
      expected_dates.push_back(shift_date(r));
    endfunction

    function int outstanding();
      return expected_dates.size();
    endfunction

    function void compare_field(string name, logic [YEAR_W-1:0] want, logic [YEAR_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(date_res_t got);
      date_res_t want;
      if (expected_dates.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, got %0d-%0d-%0d",
                 $time, got.year, got.month, got.day);
        mismatches++;
        return;
      end
      want = expected_dates.pop_front();
      n_checked++;
      if (!want.valid) n_invalid++;
      if (want.wrapped) n_wrapped++;
      compare_field("result_year", want.year, got.year);
      compare_field("result_month", YEAR_W'(want.month), YEAR_W'(got.month));
      compare_field("result_day", YEAR_W'(want.day), YEAR_W'(got.day));
      compare_field("input_valid", YEAR_W'(want.valid), YEAR_W'(got.valid));
      compare_field("year_wrapped", YEAR_W'(want.wrapped), YEAR_W'(got.wrapped));
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_opcode;
  logic [YEAR_W-1:0]  in_start_year;
  logic [MONTH_W-1:0] in_start_month;
  logic [DAY_W-1:0]   in_start_day;
  logic [COUNT_W-1:0] in_day_count;
  logic               out_valid;
  logic               out_ready;
  logic [YEAR_W-1:0]  out_result_year;
  logic [MONTH_W-1:0] out_result_month;
  logic [DAY_W-1:0]   out_result_day;
  logic               out_input_valid;
  logic               out_year_wrapped;

  date_shift_board sb;
  bit              calm;
  int              n_sent;

  calendar_date_add_sub_days #(
    .COUNT_BITS(COUNT_W),
    .YEAR_BITS (YEAR_W)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_start_year   (in_start_year),
    .in_start_month  (in_start_month),
    .in_start_day    (in_start_day),
    .in_day_count    (in_day_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_year (out_result_year),
    .out_result_month(out_result_month),
    .out_result_day  (out_result_day),
    .out_input_valid (out_input_valid),
    .out_year_wrapped(out_year_wrapped)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int pick_wait();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic date_req_t make_date(logic op, int unsigned y, int unsigned m,
                                          int unsigned d, int unsigned cnt);
    date_req_t r;
    r.op    = op;
    r.year  = YEAR_W'(y);
    r.month = MONTH_W'(m);
    r.day   = DAY_W'(d);
    r.count = COUNT_W'(cnt);
    return r;
  endfunction

  // Mostly well-formed dates; the rest are raw field values, often invalid.
  function automatic date_req_t random_request();
    date_req_t   r;
    int unsigned y, m, sel;
    r.op = $urandom_range(0, 1) ? OP_SUB : OP_ADD;
    sel = $urandom_range(0, 5);
    case (sel)
      0:       y = $urandom_range(0, 3);
      1:       y = $urandom_range(YEAR_MAX - 3, YEAR_MAX);
      2:       y = $urandom_range(0, 163) * 400 + $urandom_range(0, 3) * 100
                   + $urandom_range(0, 4);
      default: y = $urandom_range(0, YEAR_MAX);
    endcase
    r.year = YEAR_W'(y);
    if ($urandom_range(0, 9) < 8) begin
      m = $urandom_range(1, 12);
      r.month = MONTH_W'(m);
      r.day   = DAY_W'($urandom_range(1, date_shift_board::month_length(y, m)));
    end else begin
      r.month = MONTH_W'($urandom_range(0, 15));
      r.day   = DAY_W'($urandom_range(0, 31));
    end
    // keep most walks short; a fifth span the whole count range
    sel = $urandom_range(0, 9);
    if (sel == 0)      r.count = '0;
    else if (sel <= 6) r.count = COUNT_W'($urandom_range(1, 800));
    else if (sel == 7) r.count = COUNT_W'($urandom_range(801, 5000));
    else               r.count = COUNT_W'($urandom_range(0, COUNT_MAX));
    return r;
  endfunction

  task automatic send_request(date_req_t r);
    int gap;
    gap = pick_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= r.op;
    in_start_year  <= r.year;
    in_start_month <= r.month;
    in_start_day   <= r.day;
    in_day_count   <= r.count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(r);
    n_sent++;
  endtask

  // Hold the input side until every pending date has come back.
  task automatic wait_all_returned();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    sb             = new();
    calm           = 1'b0;
    n_sent         = 0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = OP_ADD;
    in_start_year  = '0;
    in_start_month = '0;
    in_start_day   = '0;
    in_day_count   = '0;
    out_ready      = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // zero counts echo the date
    send_request(make_date(OP_ADD, 2024, 5, 15, 0));
    send_request(make_date(OP_SUB, 2024, 5, 15, 0));
    // invalid starting dates are echoed untouched
    send_request(make_date(OP_ADD, 2023, 0, 10, 5));
    send_request(make_date(OP_SUB, 2023, 13, 10, 5));
    send_request(make_date(OP_ADD, YEAR_MAX, 15, 31, COUNT_MAX));
    send_request(make_date(OP_ADD, 2023, 4, 0, 3));
    send_request(make_date(OP_SUB, 2023, 4, 31, 3));
    send_request(make_date(OP_ADD, 1900, MONTH_FEB, 29, 1));
    send_request(make_date(OP_ADD, 0, 0, 0, 0));
    // leap rule around February
    send_request(make_date(OP_ADD, 2000, MONTH_FEB, 29, 1));
    send_request(make_date(OP_ADD, 2000, MONTH_FEB, 28, 1));
    send_request(make_date(OP_SUB, 2000, 3, 1, 1));
    send_request(make_date(OP_SUB, 2100, 3, 1, 1));
    send_request(make_date(OP_ADD, 2024, MONTH_FEB, 28, 1));
    send_request(make_date(OP_ADD, 0, MONTH_FEB, 29, 365));
    send_request(make_date(OP_ADD, 2023, MONTH_JAN, 31, 29));
    send_request(make_date(OP_SUB, 2023, MONTH_DEC, 31, 31));
    // year range wrap at both ends
    send_request(make_date(OP_ADD, YEAR_MAX, MONTH_DEC, 31, 1));
    send_request(make_date(OP_SUB, 0, MONTH_JAN, 1, 1));
    send_request(make_date(OP_ADD, 65500, MONTH_JAN, 1, COUNT_MAX));
    send_request(make_date(OP_SUB, 50, 6, 15, COUNT_MAX));
    send_request(make_date(OP_ADD, 0, MONTH_JAN, 1, COUNT_MAX));
    send_request(make_date(OP_SUB, YEAR_MAX, MONTH_DEC, 31, COUNT_MAX));
    send_request(make_date(OP_SUB, 1999, MONTH_DEC, 31, COUNT_MAX));

    wait_all_returned();

    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 120 && i < 160);
      if (i == 200) wait_all_returned();
      send_request(random_request());
    end

    wait_all_returned();
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Sent %0d date shifts and checked %0d results.", n_sent, sb.n_checked);
    $display("%0d had an invalid start date, %0d wrapped the year range.",
             sb.n_invalid, sb.n_wrapped);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("[calendar_date_add_sub_days] OK");
    end else begin
      $display("[calendar_date_add_sub_days] ERROR");
    end
    $finish;
  end

  // Result side: random stall before each transfer, then take it.
  initial begin
    date_res_t got;
    int        stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = pick_wait();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.year    = out_result_year;
      got.month   = out_result_month;
      got.day     = out_result_day;
      got.valid   = out_input_valid;
      got.wrapped = out_year_wrapped;
      sb.check_result(got);
    end
  end

  initial begin
    #30ms;
    $display("Timed out with %0d results still pending.", sb.outstanding());
    $display("[calendar_date_add_sub_days] ERROR");
    $finish;
  end

endmodule
